// File: rtl/vps_pkg.sv
package vps_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ID_W       = 11;
	localparam int DUR_W      = 16;
	localparam int CNT_W      = 8;
	localparam int BYTE_W     = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ARM_FRAME_ID     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_DRIVE_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_COAST_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_BRAKE_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP_DRIVE_TICKS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UP_PULSE_TICKS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UP_PULSE_COUNT   = 3'd6;

	localparam logic [ID_W-1:0]  RST_ARM_FRAME_ID     = 11'd0;
	localparam logic [DUR_W-1:0] RST_DOWN_DRIVE_TICKS = 16'd100;
	localparam logic [DUR_W-1:0] RST_DOWN_COAST_TICKS = 16'd200;
	localparam logic [DUR_W-1:0] RST_DOWN_BRAKE_TICKS = 16'd80;
	localparam logic [DUR_W-1:0] RST_UP_DRIVE_TICKS   = 16'd200;
	localparam logic [DUR_W-1:0] RST_UP_PULSE_TICKS   = 16'd60;
	localparam logic [CNT_W-1:0] RST_UP_PULSE_COUNT   = 8'd3;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	localparam logic [BYTE_W-1:0] REQ_UP   = 8'd0;
	localparam logic [BYTE_W-1:0] REQ_DOWN = 8'd1;

	typedef enum logic [1:0] {
		POS_UNKNOWN = 2'd0,
		POS_UP      = 2'd1,
		POS_DOWN    = 2'd2
	} pos_t;

	typedef struct packed {
		logic [ID_W-1:0]  arm_frame_id;
		logic [DUR_W-1:0] down_drive_ticks;
		logic [DUR_W-1:0] down_coast_ticks;
		logic [DUR_W-1:0] down_brake_ticks;
		logic [DUR_W-1:0] up_drive_ticks;
		logic [DUR_W-1:0] up_pulse_ticks;
		logic [CNT_W-1:0] up_pulse_count;
	} cfg_t;

	typedef struct packed {
		logic             command;
		logic [ID_W-1:0]  frame_id;
		logic [BYTE_W-1:0] first_byte;
	} item_t;

	typedef struct packed {
		logic drive_a;
		logic drive_b;
		logic busy_res;
		logic [1:0] arm_position;
		logic run_done;
	} res_t;

endpackage

// File: rtl/vps_if.sv
interface vps_in_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [vps_pkg::ID_W-1:0]  frame_id;
	logic [vps_pkg::BYTE_W-1:0] first_byte;

	modport source (output valid, output command, output frame_id, output first_byte,
		input ready);
	modport sink (input valid, input command, input frame_id, input first_byte,
		output ready);
endinterface

interface vps_out_if;
	logic       valid;
	logic       ready;
	logic       drive_a;
	logic       drive_b;
	logic       busy_res;
	logic [1:0] arm_position;
	logic       run_done;

	modport source (output valid, output drive_a, output drive_b, output busy_res,
		output arm_position, output run_done, input ready);
	modport sink (input valid, input drive_a, input drive_b, input busy_res,
		input arm_position, input run_done, output ready);
endinterface

interface vps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [vps_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [vps_pkg::CFG_DATA_W-1:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/vps_core.sv
module vps_core #(
	parameter int TICK_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  vps_pkg::item_t item,
	input  vps_pkg::cfg_t  cfg,
	output vps_pkg::res_t  res
);

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_DOWN_DRIVE = 3'd1,
		PH_DOWN_COAST = 3'd2,
		PH_DOWN_BRAKE = 3'd3,
		PH_UP_DRIVE   = 3'd4,
		PH_UP_ON      = 3'd5,
		PH_UP_OFF     = 3'd6
	} phase_t;

	localparam int DW = (TICK_BITS > vps_pkg::DUR_W) ? TICK_BITS : vps_pkg::DUR_W;
	localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
	localparam logic [TICK_BITS-1:0] TICK_ONE = TICK_BITS'(1);

	phase_t                     phase_q, phase_d;
	logic [TICK_BITS-1:0]       ticks_q, ticks_d;
	logic [vps_pkg::CNT_W-1:0]  pulses_q, pulses_d, pulses_dec;
	vps_pkg::pos_t              pos_q, pos_d;
	logic                       line_a_q, line_a_d;
	logic                       line_b_q, line_b_d;
	logic                       done;

	function automatic logic [TICK_BITS-1:0] dur(input logic [vps_pkg::DUR_W-1:0] r);
		logic [DW-1:0] v;
		logic [DW-1:0] m;
		v = DW'(r);
		m = DW'(TICK_MAX);
		if (v == '0)
			v = DW'(1);
		if (v > m)
			v = m;
		return v[TICK_BITS-1:0];
	endfunction

	assign pulses_dec = (pulses_q != '0) ? pulses_q - 1'b1 : pulses_q;

	always_comb begin
		phase_d  = phase_q;
		ticks_d  = ticks_q;
		pulses_d = pulses_q;
		pos_d    = pos_q;
		line_a_d = line_a_q;
		line_b_d = line_b_q;
		done     = 1'b0;
		if (item.command == vps_pkg::CMD_FRAME) begin
			if (phase_q == PH_IDLE && item.frame_id == cfg.arm_frame_id) begin
				if (item.first_byte == vps_pkg::REQ_UP && pos_q != vps_pkg::POS_UP) begin
					pulses_d = cfg.up_pulse_count;
					phase_d  = PH_UP_DRIVE;
					line_a_d = 1'b0;
					line_b_d = 1'b1;
					ticks_d  = dur(cfg.up_drive_ticks);
				end else if (item.first_byte == vps_pkg::REQ_DOWN
						&& pos_q != vps_pkg::POS_DOWN) begin
					phase_d  = PH_DOWN_DRIVE;
					line_a_d = 1'b1;
					line_b_d = 1'b0;
					ticks_d  = dur(cfg.down_drive_ticks);
				end
			end
		end else if (phase_q != PH_IDLE) begin
			if (ticks_q > TICK_ONE) begin
				ticks_d = ticks_q - TICK_ONE;
			end else begin
				unique case (phase_q)
					PH_DOWN_DRIVE: begin
						phase_d  = PH_DOWN_COAST;
						line_a_d = 1'b0;
						line_b_d = 1'b0;
						ticks_d  = dur(cfg.down_coast_ticks);
					end
					PH_DOWN_COAST: begin
						phase_d  = PH_DOWN_BRAKE;
						line_a_d = 1'b0;
						line_b_d = 1'b1;
						ticks_d  = dur(cfg.down_brake_ticks);
					end
					PH_DOWN_BRAKE: begin
						phase_d  = PH_IDLE;
						line_a_d = 1'b0;
						line_b_d = 1'b0;
						ticks_d  = '0;
						pulses_d = '0;
						pos_d    = vps_pkg::POS_DOWN;
						done     = 1'b1;
					end
					PH_UP_DRIVE: begin
						if (pulses_q != '0) begin
							phase_d  = PH_UP_ON;
							line_a_d = 1'b0;
							line_b_d = 1'b1;
							ticks_d  = dur(cfg.up_pulse_ticks);
						end else begin
							phase_d  = PH_IDLE;
							line_a_d = 1'b0;
							line_b_d = 1'b1;
							ticks_d  = '0;
							pulses_d = '0;
							pos_d    = vps_pkg::POS_UP;
							done     = 1'b1;
						end
					end
					PH_UP_ON: begin
						phase_d  = PH_UP_OFF;
						line_a_d = 1'b0;
						line_b_d = 1'b0;
						ticks_d  = dur(cfg.up_pulse_ticks);
					end
					PH_UP_OFF: begin
						if (pulses_dec != '0) begin
							phase_d  = PH_UP_ON;
							pulses_d = pulses_dec;
							line_a_d = 1'b0;
							line_b_d = 1'b1;
							ticks_d  = dur(cfg.up_pulse_ticks);
						end else begin
							phase_d  = PH_IDLE;
							line_a_d = 1'b0;
							line_b_d = 1'b1;
							ticks_d  = '0;
							pulses_d = '0;
							pos_d    = vps_pkg::POS_UP;
							done     = 1'b1;
						end
					end
					default: begin
						phase_d  = PH_IDLE;
						line_a_d = 1'b0;
						line_b_d = 1'b0;
						ticks_d  = '0;
						pulses_d = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			ticks_q  <= '0;
			pulses_q <= '0;
			pos_q    <= vps_pkg::POS_UNKNOWN;
			line_a_q <= 1'b0;
			line_b_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			ticks_q  <= ticks_d;
			pulses_q <= pulses_d;
			pos_q    <= pos_d;
			line_a_q <= line_a_d;
			line_b_q <= line_b_d;
		end
	end

	assign res.drive_a      = line_a_d;
	assign res.drive_b      = line_b_d;
	assign res.busy_res     = (phase_d != PH_IDLE);
	assign res.arm_position = pos_d;
	assign res.run_done     = done;

endmodule

// File: rtl/valve_pulse_sequencer_top.sv
// Valve pulse sequencer: each word on in_ch (a millisecond tick or a received frame) yields
// exactly one result word on out_ch carrying the valve line levels, the busy flag, the arm
// position and a run-done flag, all as they stand after that word. The sequencer state and a
// single output register are updated in the cycle a word is accepted, so one word is taken
// every clock while out_ch keeps up; in_ch stalls only while the output register holds a word
// that out_ch has not taken. The result word is registered and offered in the cycle after acceptance.
// Configuration writes on cfg_ch are taken every cycle and should be issued while idle.
module valve_pulse_sequencer_top #(
	parameter int TICK_BITS = 16
) (
	input logic            clk,
	input logic            arst_n,
	vps_in_if.sink         in_ch,
	vps_out_if.source      out_ch,
	vps_cfg_if.sink        cfg_ch
);

	vps_pkg::cfg_t  cfg_q;
	vps_pkg::item_t item;
	vps_pkg::res_t  res;
	vps_pkg::res_t  res_q;
	logic           out_valid_q;
	logic           accept;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = !out_valid_q || out_ch.ready;
	assign accept       = in_ch.valid && in_ch.ready;

	assign item.command    = in_ch.command;
	assign item.frame_id   = in_ch.frame_id;
	assign item.first_byte = in_ch.first_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_frame_id     <= vps_pkg::RST_ARM_FRAME_ID;
			cfg_q.down_drive_ticks <= vps_pkg::RST_DOWN_DRIVE_TICKS;
			cfg_q.down_coast_ticks <= vps_pkg::RST_DOWN_COAST_TICKS;
			cfg_q.down_brake_ticks <= vps_pkg::RST_DOWN_BRAKE_TICKS;
			cfg_q.up_drive_ticks   <= vps_pkg::RST_UP_DRIVE_TICKS;
			cfg_q.up_pulse_ticks   <= vps_pkg::RST_UP_PULSE_TICKS;
			cfg_q.up_pulse_count   <= vps_pkg::RST_UP_PULSE_COUNT;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.reg_index)
				vps_pkg::REG_ARM_FRAME_ID:
					cfg_q.arm_frame_id <= cfg_ch.wr_data[vps_pkg::ID_W-1:0];
				vps_pkg::REG_DOWN_DRIVE_TICKS: cfg_q.down_drive_ticks <= cfg_ch.wr_data;
				vps_pkg::REG_DOWN_COAST_TICKS: cfg_q.down_coast_ticks <= cfg_ch.wr_data;
				vps_pkg::REG_DOWN_BRAKE_TICKS: cfg_q.down_brake_ticks <= cfg_ch.wr_data;
				vps_pkg::REG_UP_DRIVE_TICKS:   cfg_q.up_drive_ticks   <= cfg_ch.wr_data;
				vps_pkg::REG_UP_PULSE_TICKS:   cfg_q.up_pulse_ticks   <= cfg_ch.wr_data;
				vps_pkg::REG_UP_PULSE_COUNT:
					cfg_q.up_pulse_count <= cfg_ch.wr_data[vps_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	vps_core #(
		.TICK_BITS (TICK_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.drive_a      = res_q.drive_a;
	assign out_ch.drive_b      = res_q.drive_b;
	assign out_ch.busy_res     = res_q.busy_res;
	assign out_ch.arm_position = res_q.arm_position;
	assign out_ch.run_done     = res_q.run_done;

endmodule

// File: rtl/vps_checker.sv
module vps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       drive_a,
	input logic       drive_b,
	input logic       busy_res,
	input logic [1:0] arm_position,
	input logic       run_done
);

	// never open both lines at once
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_a && drive_b))
		else $error("both valve lines driven");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && run_done) |-> (!busy_res && arm_position != 2'd0))
		else $error("run end without idle and known position");

	// line A is only ever driven inside a down run
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_a) |-> busy_res)
		else $error("line A driven while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(drive_a) && $stable(drive_b)
			&& $stable(busy_res) && $stable(arm_position) && $stable(run_done)))
		else $error("stalled result word changed");

endmodule

bind valve_pulse_sequencer_top vps_checker u_vps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.drive_a      (out_ch.drive_a),
	.drive_b      (out_ch.drive_b),
	.busy_res     (out_ch.busy_res),
	.arm_position (out_ch.arm_position),
	.run_done     (out_ch.run_done)
);
